FILE: src/ppmd_pkg.sv
// ----------------------------------------------------------------------------
// PPM decoder package
// Shared types, register codes and constants for the PPM pulse train decoder.
// ----------------------------------------------------------------------------
package ppmd_pkg;

  localparam int unsigned MAX_CHANNELS = 16;
  localparam int unsigned TIME_W       = 16;
  localparam int unsigned CNT_W        = 5;
  localparam int unsigned IDX_W        = 4;
  localparam int unsigned FRAME_W      = 32;
  localparam int unsigned CFG_IDX_W    = 2;

  localparam logic [TIME_W-1:0] GLITCH_RST  = 16'd400;
  localparam logic [TIME_W-1:0] SYNC_RST    = 16'd4000;
  localparam logic [TIME_W-1:0] NEUTRAL_RST = 16'd1500;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GLITCH  = 2'd0,
    REG_SYNC    = 2'd1,
    REG_NEUTRAL = 2'd2,
    REG_ENABLE  = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_GLITCH   = 3'd0,
    ST_STORED   = 3'd1,
    ST_SYNC     = 3'd2,
    ST_DROPPED  = 3'd3,
    ST_DISABLED = 3'd4
  } status_e;

  typedef struct packed {
    logic [TIME_W-1:0] glitch_limit;
    logic [TIME_W-1:0] sync_limit;
    logic [TIME_W-1:0] neutral_width;
    logic              capture_enabled;
  } cfg_t;

  typedef struct packed {
    status_e                  status;
    logic [IDX_W-1:0]         channel_index;
    logic signed [TIME_W-1:0] channel_value;
    logic [FRAME_W-1:0]       frame_total;
    logic [CNT_W-1:0]         channels_last_frame;
  } res_t;

endpackage

FILE: src/ppmd_if.sv
// ----------------------------------------------------------------------------
// PPM decoder channels
// Valid/ready interfaces for the edge requests and the decode results.
// ----------------------------------------------------------------------------
interface ppmd_in_if import ppmd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] edge_time;

  modport source (output valid, output edge_time, input ready);
  modport sink   (input valid, input edge_time, output ready);
endinterface

interface ppmd_out_if import ppmd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [2:0]               status;
  logic [IDX_W-1:0]         channel_index;
  logic signed [TIME_W-1:0] channel_value;
  logic [FRAME_W-1:0]       frame_total;
  logic [CNT_W-1:0]         channels_last_frame;

  modport source (output valid, output status, output channel_index, output channel_value,
                  output frame_total, output channels_last_frame, input ready);
  modport sink   (input valid, input status, input channel_index, input channel_value,
                  input frame_total, input channels_last_frame, output ready);
endinterface

FILE: src/ppm_pulse_train_decoder.sv
// ----------------------------------------------------------------------------
// PPM pulse train decoder
// Turns captured falling-edge timer values into channel, sync and glitch reports.
// ----------------------------------------------------------------------------
// Usage:
//   in_s  : one request per falling edge, carrying the 16-bit timer capture.
//   out_s : exactly one result per request, in request order.
//   cfg   : cfg_we_i/cfg_idx_i/cfg_wdata_i write glitch limit (0), sync limit (1),
//           neutral width (2) and capture enable (3); write only while idle.
// Path: a request taken into the input register is decoded by two subtracts and
//   three compares, and its result is loaded into the result register and shows on
//   out_s as soon as that register is free or being read out.
// Throughput: one request per cycle unless out_s stalls, set by the input and result
//   registers advancing together; frame state updates when a result is loaded.
// Reset: capture is disabled, limits return to 400/4000/1500, the edge time,
//   channel counters and frame counter clear, and both registers empty.
// Stall: a held result keeps its value; one more request is taken into the input
//   register, then in_s.ready drops until out_s.ready frees the result register.
// ----------------------------------------------------------------------------
module ppm_pulse_train_decoder import ppmd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  ppmd_in_if.sink              in_s,
  ppmd_out_if.source           out_s,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [TIME_W-1:0]    cfg_wdata_i
);

  cfg_t              cfg;
  res_t              res;
  res_t              out_q;
  logic              in_vld_q, out_vld_q;
  logic [TIME_W-1:0] in_time_q;
  logic              adv;

  ppmd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  ppmd_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .adv_i       (adv),
    .edge_time_i (in_time_q),
    .res_o       (res)
  );

  assign adv        = in_vld_q && (!out_vld_q || out_s.ready);
  assign in_s.ready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_s.ready) begin
        in_vld_q <= in_s.valid;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (out_s.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_s.valid && in_s.ready) begin
      in_time_q <= in_s.edge_time;
    end
    if (adv) begin
      out_q <= res;
    end
  end

  assign out_s.valid               = out_vld_q;
  assign out_s.status              = out_q.status;
  assign out_s.channel_index       = out_q.channel_index;
  assign out_s.channel_value       = out_q.channel_value;
  assign out_s.frame_total         = out_q.frame_total;
  assign out_s.channels_last_frame = out_q.channels_last_frame;

  a_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_s.valid && (out_s.status != ST_STORED) |->
      (out_s.channel_index == '0) && (out_s.channel_value == '0))
    else $error("channel fields set on a non-channel result");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_s.valid |-> out_s.channels_last_frame <= CNT_W'(MAX_CHANNELS))
    else $error("latched channel count beyond maximum");

  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_s.ready |-> in_vld_q && out_vld_q && !out_s.ready)
    else $error("input stalled while pipeline has room");

endmodule

FILE: src/ppmd_cfg.sv
// ----------------------------------------------------------------------------
// PPM decoder configuration registers
// Holds glitch limit, sync limit, neutral width and capture enable.
// ----------------------------------------------------------------------------
module ppmd_cfg import ppmd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [TIME_W-1:0]    cfg_wdata_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_GLITCH:  cfg_d.glitch_limit    = cfg_wdata_i;
        REG_SYNC:    cfg_d.sync_limit      = cfg_wdata_i;
        REG_NEUTRAL: cfg_d.neutral_width   = cfg_wdata_i;
        REG_ENABLE:  cfg_d.capture_enabled = cfg_wdata_i[0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.glitch_limit    <= GLITCH_RST;
      cfg_q.sync_limit      <= SYNC_RST;
      cfg_q.neutral_width   <= NEUTRAL_RST;
      cfg_q.capture_enabled <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: src/ppmd_decode.sv
// ----------------------------------------------------------------------------
// PPM decoder classification
// Measures the pulse width, classifies it and keeps the frame state.
// ----------------------------------------------------------------------------
module ppmd_decode import ppmd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              adv_i,
  input  logic [TIME_W-1:0] edge_time_i,
  output res_t              res_o
);

  logic [TIME_W-1:0]  prev_q, prev_d;
  logic [CNT_W-1:0]   next_ch_q, next_ch_d;
  logic [CNT_W-1:0]   latched_q, latched_d;
  logic [FRAME_W-1:0] frames_q, frames_d;
  logic [TIME_W-1:0]  width;

  assign width = edge_time_i - prev_q;

  always_comb begin
    prev_d    = prev_q;
    next_ch_d = next_ch_q;
    latched_d = latched_q;
    frames_d  = frames_q;
    res_o.status        = ST_DISABLED;
    res_o.channel_index = '0;
    res_o.channel_value = '0;
    if (cfg_i.capture_enabled) begin
      if (width <= cfg_i.glitch_limit) begin
        res_o.status = ST_GLITCH;
      end else begin
        prev_d = edge_time_i;
        if (width >= cfg_i.sync_limit) begin
          frames_d     = frames_q + FRAME_W'(1);
          latched_d    = next_ch_q;
          next_ch_d    = '0;
          res_o.status = ST_SYNC;
        end else if (next_ch_q < CNT_W'(MAX_CHANNELS)) begin
          res_o.channel_index = next_ch_q[IDX_W-1:0];
          res_o.channel_value = width - cfg_i.neutral_width;
          next_ch_d           = next_ch_q + CNT_W'(1);
          res_o.status        = ST_STORED;
        end else begin
          res_o.status = ST_DROPPED;
        end
      end
    end
    res_o.frame_total         = frames_d;
    res_o.channels_last_frame = latched_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q    <= '0;
      next_ch_q <= '0;
      latched_q <= '0;
      frames_q  <= '0;
    end else if (adv_i) begin
      prev_q    <= prev_d;
      next_ch_q <= next_ch_d;
      latched_q <= latched_d;
      frames_q  <= frames_d;
    end
  end

endmodule

FILE: tb/ppm_pulse_train_decoder_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PPM pulse train decoder testbench
// Feeds falling-edge timer captures through the valid/ready request channel:
// directed widths around the glitch and sync limits, then framed pulse trains
// with random content, noise, cut-short and overlong frames over a range of
// limit settings. A local decoder predicts every report, and each accepted
// report is checked field by field in order. Both sides idle in random bursts,
// and the report side holds off once long enough to back up the input.
// ----------------------------------------------------------------------------
module ppm_pulse_train_decoder_test;
  import ppmd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned LONG_HOLD   = 150;

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     cfg_we_i;
  cfg_reg_e cfg_idx_i;
  logic [TIME_W-1:0] cfg_wdata_i;

  ppmd_in_if  in_if ();
  ppmd_out_if out_if ();

  ppm_pulse_train_decoder u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_s        (in_if),
    .out_s       (out_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // decoder state and settings as seen by the predictor
  cfg_t               dec_cfg;
  logic [TIME_W-1:0]  dec_prev_time;
  logic [CNT_W-1:0]   dec_next_ch;
  logic [CNT_W-1:0]   dec_ch_count;
  logic [FRAME_W-1:0] dec_frames;

  logic [TIME_W-1:0] queued_edges[$];
  res_t              awaited_reports[$];
  logic [TIME_W-1:0] gen_time;

  int unsigned edges_planned;
  int unsigned reports_checked;
  int unsigned settings_used;
  int unsigned status_total[5];
  int unsigned failures;
  int unsigned cycle_count;
  int unsigned idle_pct;
  int unsigned send_gap;
  int unsigned stall_left;
  int unsigned long_holds_asked;
  int unsigned long_holds_seen;
  bit          edge_taken;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic res_t decode_edge(input logic [TIME_W-1:0] stamp);
    res_t r;
    logic [TIME_W-1:0] width;
    r = '0;
    width = stamp - dec_prev_time;
    if (!dec_cfg.capture_enabled) begin
      r.status = ST_DISABLED;
    end else if (width <= dec_cfg.glitch_limit) begin
      r.status = ST_GLITCH;
    end else begin
      dec_prev_time = stamp;
      if (width >= dec_cfg.sync_limit) begin
        r.status = ST_SYNC;
        dec_frames = dec_frames + 1'b1;
        dec_ch_count = dec_next_ch;
        dec_next_ch = '0;
      end else if (dec_next_ch < MAX_CHANNELS) begin
        r.status = ST_STORED;
        r.channel_index = dec_next_ch[IDX_W-1:0];
        r.channel_value = width - dec_cfg.neutral_width;
        dec_next_ch = dec_next_ch + 1'b1;
      end else begin
        r.status = ST_DROPPED;
      end
    end
    r.frame_total = dec_frames;
    r.channels_last_frame = dec_ch_count;
    return r;
  endfunction

  // track the edge time the decoder will hold, so frames line up with it
  function automatic void push_edge(input logic [TIME_W-1:0] stamp);
    logic [TIME_W-1:0] width;
    width = stamp - gen_time;
    if (dec_cfg.capture_enabled && width > dec_cfg.glitch_limit) gen_time = stamp;
    queued_edges.push_back(stamp);
    edges_planned++;
  endfunction

  function automatic void queue_frame(input int unsigned nch, input bit with_sync);
    int lo;
    int hi;
    int sy_lo;
    int w;
    lo = int'(dec_cfg.glitch_limit) + 1;
    hi = int'(dec_cfg.sync_limit) - 1;
    sy_lo = (int'(dec_cfg.sync_limit) > lo) ? int'(dec_cfg.sync_limit) : lo;
    for (int k = 0; k < nch; k++) begin
      if ($urandom_range(0, 7) == 0) push_edge(gen_time + 16'($urandom_range(0, lo - 1)));
      if (lo <= hi) begin
        case ($urandom_range(0, 5))
          0:       w = lo;
          1:       w = hi;
          default: w = $urandom_range(lo, hi);
        endcase
        push_edge(gen_time + 16'(w));
      end
    end
    if (with_sync && sy_lo <= 65535) begin
      if ($urandom_range(0, 3) == 0) w = $urandom_range(sy_lo, 65535);
      else w = $urandom_range(sy_lo, (sy_lo + 3000 > 65535) ? 65535 : sy_lo + 3000);
      push_edge(gen_time + 16'(w));
    end
  endfunction

  function automatic void queue_traffic(input int unsigned n);
    int unsigned stop_at;
    int unsigned pick;
    bit          framed;
    stop_at = edges_planned + n;
    framed = dec_cfg.capture_enabled && dec_cfg.glitch_limit != '1;
    while (edges_planned < stop_at) begin
      pick = $urandom_range(0, 9);
      if (pick == 0 || !framed) push_edge(16'($urandom));
      else if (pick == 1) queue_frame($urandom_range(1, 6), 1'b0);
      else if (pick == 2) queue_frame($urandom_range(17, 20), 1'b1);
      else queue_frame($urandom_range(0, 16), 1'b1);
    end
  endfunction

  task automatic wait_quiet;
    while (queued_edges.size() != 0 || in_if.valid || awaited_reports.size() != 0)
      @(posedge clk_i);
    gen_time = dec_prev_time;
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [TIME_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_GLITCH:  dec_cfg.glitch_limit = data;
      REG_SYNC:    dec_cfg.sync_limit = data;
      REG_NEUTRAL: dec_cfg.neutral_width = data;
      REG_ENABLE:  dec_cfg.capture_enabled = data[0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [TIME_W-1:0] glitch, input logic [TIME_W-1:0] sync,
                                input logic [TIME_W-1:0] neutral, input bit enable);
    wait_quiet();
    write_reg(REG_GLITCH, glitch);
    write_reg(REG_SYNC, sync);
    write_reg(REG_NEUTRAL, neutral);
    write_reg(REG_ENABLE, TIME_W'(enable));
    settings_used++;
  endtask

  // record requests, predict, and check reports
  always @(posedge clk_i) begin
    res_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d reports still awaited", cycle_count,
               awaited_reports.size());
      $display("Test completed with failures");
      $finish;
    end else if (rst_ni) begin
      edge_taken = in_if.valid && in_if.ready;
      if (edge_taken) begin
        want = decode_edge(in_if.edge_time);
        status_total[int'(want.status)]++;
        awaited_reports.push_back(want);
      end
      if (out_if.valid && out_if.ready) begin
        if (awaited_reports.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("Unexpected report at cycle %0d: status %0d", cycle_count, out_if.status);
        end else begin
          want = awaited_reports.pop_front();
          reports_checked++;
          if (out_if.status !== want.status || out_if.channel_index !== want.channel_index ||
              out_if.channel_value !== want.channel_value ||
              out_if.frame_total !== want.frame_total ||
              out_if.channels_last_frame !== want.channels_last_frame) begin
            failures++;
            if (failures <= 10) begin
              $display("Mismatch at cycle %0d, report %0d:", cycle_count, reports_checked);
              $display("  want status %0d idx %0d value %0d frames %0d count %0d",
                       want.status, want.channel_index, want.channel_value,
                       want.frame_total, want.channels_last_frame);
              $display("  got  status %0d idx %0d value %0d frames %0d count %0d",
                       out_if.status, out_if.channel_index, out_if.channel_value,
                       out_if.frame_total, out_if.channels_last_frame);
            end
          end
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (!in_if.valid || edge_taken) begin
      if (send_gap != 0) begin
        send_gap--;
        in_if.valid <= 1'b0;
      end else if (queued_edges.size() != 0 && $urandom_range(0, 99) < idle_pct) begin
        send_gap = $urandom_range(0, 6);
        in_if.valid <= 1'b0;
      end else if (queued_edges.size() != 0) begin
        in_if.valid     <= 1'b1;
        in_if.edge_time <= queued_edges.pop_front();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (long_holds_seen != long_holds_asked) begin
      long_holds_seen = long_holds_asked;
      stall_left = LONG_HOLD - 1;
      out_if.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else if ($urandom_range(0, 99) < idle_pct) begin
      stall_left = $urandom_range(0, 6);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = REG_GLITCH;
    cfg_wdata_i     = '0;
    in_if.valid     = 1'b0;
    in_if.edge_time = '0;
    out_if.ready    = 1'b0;
    idle_pct        = 10;
    dec_cfg         = '{GLITCH_RST, SYNC_RST, NEUTRAL_RST, 1'b0};
    dec_prev_time   = '0;
    dec_next_ch     = '0;
    dec_ch_count    = '0;
    dec_frames      = '0;
    gen_time        = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // capture is off after reset
    push_edge(16'h0000);
    push_edge(16'hFFFF);
    apply_settings(GLITCH_RST, SYNC_RST, NEUTRAL_RST, 1'b1);
    push_edge(gen_time);
    push_edge(gen_time + 16'd400);
    push_edge(gen_time + 16'd401);
    push_edge(gen_time + 16'd3999);
    push_edge(gen_time + 16'd4000);
    push_edge(gen_time + 16'd1500);
    push_edge(gen_time + 16'd401);
    push_edge(gen_time + 16'd60000);
    push_edge(16'hFF00);
    push_edge(16'h0200);
    push_edge(gen_time + 16'd1000);
    push_edge(gen_time + 16'd399);
    push_edge(gen_time + 16'd2200);
    push_edge(gen_time + 16'hFFFF);
    push_edge(gen_time + 16'd4001);

    // hold the report side while requests keep coming
    wait_quiet();
    queue_traffic(300);
    long_holds_asked++;

    apply_settings(16'd0, 16'hFFFF, 16'd0, 1'b1);
    idle_pct = 30;
    queue_traffic(150);

    apply_settings(16'hFFFF, 16'd0, 16'hFFFF, 1'b1);
    idle_pct = 0;
    queue_traffic(60);

    apply_settings(16'd3000, 16'd1000, 16'h8000, 1'b1);
    idle_pct = 15;
    queue_traffic(100);

    apply_settings(16'd100, 16'd0, 16'h7FFF, 1'b1);
    queue_traffic(100);

    apply_settings(16'($urandom), 16'($urandom), 16'($urandom), 1'b0);
    idle_pct = 25;
    queue_traffic(60);

    for (int k = 0; k < 3; k++) begin
      int unsigned g;
      g = $urandom_range(0, 1000);
      apply_settings(16'(g), 16'($urandom_range(g + 500, 6000)), 16'($urandom), 1'b1);
      idle_pct = (k == 1) ? 0 : 20;
      queue_traffic(200);
    end

    apply_settings(GLITCH_RST, SYNC_RST, NEUTRAL_RST, 1'b1);
    idle_pct = 0;
    queue_traffic(250);

    wait_quiet();
    repeat (4) @(posedge clk_i);
    $display("Checked %0d reports from %0d edges over %0d register settings",
             reports_checked, edges_planned, settings_used);
    $display("Stored %0d, sync %0d, glitch %0d, dropped %0d, disabled %0d; %0d failures",
             status_total[ST_STORED], status_total[ST_SYNC], status_total[ST_GLITCH],
             status_total[ST_DROPPED], status_total[ST_DISABLED], failures);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
